/* sv/llc_pkg.sv */
`default_nettype none
package llc_pkg;

    // default pool depth
    localparam int POOL_NODES_DEF = 256;

    // operation codes
    localparam logic [3:0] OP_CLEAR      = 4'd0;
    localparam logic [3:0] OP_INS_FIRST  = 4'd1;
    localparam logic [3:0] OP_INS_LAST   = 4'd2;
    localparam logic [3:0] OP_CUR_FIRST  = 4'd3;
    localparam logic [3:0] OP_CUR_LAST   = 4'd4;
    localparam logic [3:0] OP_DEL_FIRST  = 4'd5;
    localparam logic [3:0] OP_DEL_LAST   = 4'd6;
    localparam logic [3:0] OP_DEL_AFTER  = 4'd7;
    localparam logic [3:0] OP_DEL_BEFORE = 4'd8;
    localparam logic [3:0] OP_INS_AFTER  = 4'd9;
    localparam logic [3:0] OP_INS_BEFORE = 4'd10;
    localparam logic [3:0] OP_OVERWRITE  = 4'd11;
    localparam logic [3:0] OP_NEXT       = 4'd12;
    localparam logic [3:0] OP_PREV       = 4'd13;
    localparam logic [3:0] OP_QUERY      = 4'd14;

    // status codes
    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_FAIL = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [3:0]         operation;
        logic signed [31:0] item_value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] first_value;
        logic signed [31:0] last_value;
        logic signed [31:0] cursor_value;
        logic               list_empty;
        logic               cursor_active;
        logic [8:0]         element_count;
        logic [1:0]         status;
    } out_t;

    // controller to datapath: one strobe per sequencer step
    typedef struct packed {
        logic latch;
        logic dec;
        logic clnk;
        logic take;
        logic ins1;
        logic ins2;
        logic del0;
        logic del1;
        logic del2;
        logic cval;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic pre_ok;
        logic pool_ok;
        logic lnk_ok;
        logic simple;
        logic cur_op;
        logic ins;
        logic del;
        logic move;
    } sts_t;

endpackage
`default_nettype wire

/* sv/linked_list_cursor_engine.sv */
`default_nettype none
// Doubly linked list with cursor over a fixed node pool.
// Command channel: request (operation, item_value) is taken at a rising
// edge with start high and busy low. busy stays high until the result
// beat has been shown.
// Result channel: result is valid for exactly one cycle with done high;
// the receiver cannot stall it, it must take the beat in that cycle.
// Steps after accept: decode, then the result beat for clear, cursor to
// either end, overwrite, query and refused operations; next/prev add a
// cursor link read and, if valid, a cursor value read; insert adds
// take, ins1, ins2 and delete del0, del1, del2, both after a cursor
// link read when next to the cursor. The block goes idle after the
// result beat before it takes the next request. The pool memories set
// the steps: each link lookup is a registered read, and insert writes
// the node and its neighbors in separate steps. Reset empties the list
// at once; clear is constant time since nodes come from a recycled
// chain and then a fresh region, so the pools need no clearing pass.
module linked_list_cursor_engine #(
    parameter int POOL_NODES = llc_pkg::POOL_NODES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire llc_pkg::in_t request,
    output logic              done,
    output llc_pkg::out_t     result
);
    llc_pkg::cmd_t cmd;
    llc_pkg::sts_t sts;

    llc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    llc_datapath #(
        .POOL_NODES (POOL_NODES)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .request (request),
        .sts     (sts),
        .result  (result)
    );

endmodule
`default_nettype wire

/* sv/llc_datapath.sv */
`default_nettype none
module llc_datapath #(
    parameter int POOL_NODES = llc_pkg::POOL_NODES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire llc_pkg::cmd_t cmd,
    input  wire llc_pkg::in_t  request,
    output llc_pkg::sts_t      sts,
    output llc_pkg::out_t      result
);
    localparam int AW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
    localparam int IW = $clog2(POOL_NODES + 1);
    localparam logic [IW-1:0] NIL = IW'(POOL_NODES);

    typedef logic [IW-1:0] idx_t;

    function automatic logic vld(input idx_t i);
        return i < NIL;
    endfunction

    // pool memories
    logic [31:0] value_mem [POOL_NODES];
    idx_t        next_mem  [POOL_NODES];
    idx_t        prev_mem  [POOL_NODES];

    logic        v_we, n_we, p_we;
    idx_t        v_wa, n_wa, p_wa, v_ra, n_ra, p_ra;
    logic [31:0] v_wd, v_rd;
    idx_t        n_wd, p_wd, n_rd, p_rd;

    // list state
    logic [3:0]  op_reg, op_next;
    logic [31:0] val_reg, val_next;
    idx_t first_reg, first_next, last_reg, last_next, cur_reg, cur_next;
    idx_t count_reg, count_next, free_reg, free_next, fresh_reg, fresh_next;
    idx_t n_reg, n_next, p_reg, p_next, q_reg, q_next;
    logic        took_reg, took_next;
    logic [1:0]  st_reg, st_next;
    logic [31:0] fv_reg, fv_next, lv_reg, lv_next, cv_reg, cv_next;

    logic fwd, act;
    idx_t lnk;

    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            value_mem[v_wa[AW-1:0]] <= v_wd;
        end
        if (n_we)
        begin
            next_mem[n_wa[AW-1:0]] <= n_wd;
        end
        if (p_we)
        begin
            prev_mem[p_wa[AW-1:0]] <= p_wd;
        end
        v_rd <= value_mem[v_ra[AW-1:0]];
        n_rd <= next_mem[n_ra[AW-1:0]];
        p_rd <= prev_mem[p_ra[AW-1:0]];
    end

    // decode
    assign fwd = (op_reg == llc_pkg::OP_DEL_AFTER) || (op_reg == llc_pkg::OP_INS_AFTER)
              || (op_reg == llc_pkg::OP_NEXT);
    assign act = vld(cur_reg);
    assign lnk = fwd ? n_rd : p_rd;

    always_comb
    begin
        sts = '0;
        sts.pool_ok = vld(free_reg) || (fresh_reg < NIL);
        sts.lnk_ok  = vld(lnk);
        case (op_reg)
            llc_pkg::OP_CLEAR, llc_pkg::OP_QUERY:
            begin
                sts.pre_ok = 1'b1;
                sts.simple = 1'b1;
            end
            llc_pkg::OP_INS_FIRST, llc_pkg::OP_INS_LAST:
            begin
                sts.pre_ok = 1'b1;
                sts.ins    = 1'b1;
            end
            llc_pkg::OP_CUR_FIRST:
            begin
                sts.pre_ok = vld(first_reg);
                sts.simple = 1'b1;
            end
            llc_pkg::OP_CUR_LAST:
            begin
                sts.pre_ok = vld(last_reg);
                sts.simple = 1'b1;
            end
            llc_pkg::OP_DEL_FIRST:
            begin
                sts.pre_ok = vld(first_reg);
                sts.del    = 1'b1;
            end
            llc_pkg::OP_DEL_LAST:
            begin
                sts.pre_ok = vld(last_reg);
                sts.del    = 1'b1;
            end
            llc_pkg::OP_DEL_AFTER:
            begin
                sts.pre_ok = act && (cur_reg != last_reg);
                sts.del    = 1'b1;
                sts.cur_op = 1'b1;
            end
            llc_pkg::OP_DEL_BEFORE:
            begin
                sts.pre_ok = act && (cur_reg != first_reg);
                sts.del    = 1'b1;
                sts.cur_op = 1'b1;
            end
            llc_pkg::OP_INS_AFTER, llc_pkg::OP_INS_BEFORE:
            begin
                sts.pre_ok = act;
                sts.ins    = 1'b1;
                sts.cur_op = 1'b1;
            end
            llc_pkg::OP_OVERWRITE:
            begin
                sts.pre_ok = act;
                sts.simple = 1'b1;
            end
            llc_pkg::OP_NEXT, llc_pkg::OP_PREV:
            begin
                sts.pre_ok = act;
                sts.move   = 1'b1;
                sts.cur_op = 1'b1;
            end
            default:
            begin
                sts.pre_ok = 1'b0;
                sts.simple = 1'b1;
            end
        endcase
    end

    // next-state and memory port control
    always_comb
    begin
        op_next = op_reg;       val_next = val_reg;
        first_next = first_reg; last_next = last_reg; cur_next = cur_reg;
        count_next = count_reg; free_next = free_reg; fresh_next = fresh_reg;
        n_next = n_reg; p_next = p_reg; q_next = q_reg;
        took_next = took_reg;   st_next = st_reg;
        fv_next = fv_reg; lv_next = lv_reg; cv_next = cv_reg;
        v_we = 1'b0; n_we = 1'b0; p_we = 1'b0;
        v_wa = cur_reg; n_wa = n_reg; p_wa = n_reg;
        v_wd = val_reg; n_wd = q_reg; p_wd = p_reg;
        v_ra = lnk; n_ra = cur_reg; p_ra = cur_reg;

        if (cmd.latch)
        begin
            op_next  = request.operation;
            val_next = request.item_value;
        end

        // preconditions and single-step operations
        if (cmd.dec)
        begin
            if (!sts.pre_ok)
            begin
                st_next = llc_pkg::ST_FAIL;
            end
            else if (sts.ins && !sts.pool_ok)
            begin
                st_next = llc_pkg::ST_FULL;
            end
            else
            begin
                st_next = llc_pkg::ST_DONE;
            end
            if (sts.pre_ok)
            begin
                case (op_reg)
                    llc_pkg::OP_CLEAR:
                    begin
                        first_next = NIL; last_next = NIL; cur_next = NIL;
                        count_next = '0;  free_next = NIL; fresh_next = '0;
                    end
                    llc_pkg::OP_CUR_FIRST:
                    begin
                        cur_next = first_reg;
                        cv_next  = fv_reg;
                    end
                    llc_pkg::OP_CUR_LAST:
                    begin
                        cur_next = last_reg;
                        cv_next  = lv_reg;
                    end
                    llc_pkg::OP_OVERWRITE:
                    begin
                        v_we    = 1'b1;
                        cv_next = val_reg;
                        if (cur_reg == first_reg)
                        begin
                            fv_next = val_reg;
                        end
                        if (cur_reg == last_reg)
                        begin
                            lv_next = val_reg;
                        end
                    end
                    llc_pkg::OP_DEL_FIRST: n_next = first_reg;
                    llc_pkg::OP_DEL_LAST:  n_next = last_reg;
                    llc_pkg::OP_INS_FIRST:
                    begin
                        p_next = NIL;
                        q_next = first_reg;
                    end
                    llc_pkg::OP_INS_LAST:
                    begin
                        p_next = last_reg;
                        q_next = NIL;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        // cursor link has arrived
        if (cmd.clnk)
        begin
            if (sts.move)
            begin
                cur_next = sts.lnk_ok ? lnk : NIL;
                cv_next  = '0;
            end
            else if (sts.del)
            begin
                n_next = lnk;
            end
            else
            begin
                p_next = fwd ? cur_reg : lnk;
                q_next = fwd ? lnk : cur_reg;
            end
        end

        // node allocation: recycled chain first, then fresh region
        if (cmd.take)
        begin
            n_ra = free_reg;
            if (vld(free_reg))
            begin
                n_next    = free_reg;
                took_next = 1'b1;
            end
            else
            begin
                n_next     = fresh_reg;
                fresh_next = fresh_reg + 1'b1;
                took_next  = 1'b0;
            end
        end

        if (cmd.ins1)
        begin
            if (took_reg)
            begin
                free_next = n_rd;
            end
            v_we = 1'b1; v_wa = n_reg; v_wd = val_reg;
            n_we = 1'b1; n_wa = n_reg; n_wd = q_reg;
            p_we = 1'b1; p_wa = n_reg; p_wd = p_reg;
        end

        if (cmd.ins2)
        begin
            if (vld(p_reg))
            begin
                n_we = 1'b1; n_wa = p_reg; n_wd = n_reg;
            end
            else
            begin
                first_next = n_reg;
                fv_next    = val_reg;
            end
            if (vld(q_reg))
            begin
                p_we = 1'b1; p_wa = q_reg; p_wd = n_reg;
            end
            else
            begin
                last_next = n_reg;
                lv_next   = val_reg;
            end
            count_next = count_reg + 1'b1;
        end

        if (cmd.del0)
        begin
            n_ra = n_reg;
            p_ra = n_reg;
        end

        // unlink: push node on the free chain, fix successor
        if (cmd.del1)
        begin
            p_next    = p_rd;
            q_next    = n_rd;
            v_ra      = vld(p_rd) ? p_rd : n_rd;
            n_we      = 1'b1; n_wa = n_reg; n_wd = free_reg;
            free_next = n_reg;
            if (vld(n_rd))
            begin
                p_we = 1'b1; p_wa = n_rd; p_wd = p_rd;
            end
        end

        if (cmd.del2)
        begin
            if (vld(p_reg))
            begin
                n_we = 1'b1; n_wa = p_reg; n_wd = q_reg;
            end
            else
            begin
                first_next = q_reg;
                fv_next    = v_rd;
            end
            if (!vld(q_reg))
            begin
                last_next = p_reg;
                lv_next   = v_rd;
            end
            if (cur_reg == n_reg)
            begin
                cur_next = NIL;
            end
            if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
            end
        end

        if (cmd.cval)
        begin
            cv_next = v_rd;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= NIL;
            last_reg  <= NIL;
            cur_reg   <= NIL;
            count_reg <= '0;
            free_reg  <= NIL;
            fresh_reg <= '0;
            op_reg    <= llc_pkg::OP_QUERY;
            st_reg    <= llc_pkg::ST_DONE;
            took_reg  <= 1'b0;
        end
        else
        begin
            first_reg <= first_next;
            last_reg  <= last_next;
            cur_reg   <= cur_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            fresh_reg <= fresh_next;
            op_reg    <= op_next;
            st_reg    <= st_next;
            took_reg  <= took_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        n_reg   <= n_next;
        p_reg   <= p_next;
        q_reg   <= q_next;
        fv_reg  <= fv_next;
        lv_reg  <= lv_next;
        cv_reg  <= cv_next;
    end

    // result view
    always_comb
    begin
        result.first_value   = vld(first_reg) ? fv_reg : '0;
        result.last_value    = vld(last_reg) ? lv_reg : '0;
        result.cursor_value  = act ? cv_reg : '0;
        result.list_empty    = !vld(first_reg);
        result.cursor_active = act;
        result.element_count = 9'(count_reg);
        result.status        = st_reg;
    end

endmodule
`default_nettype wire

/* sv/llc_ctrl.sv */
`default_nettype none
module llc_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire llc_pkg::sts_t sts,
    output llc_pkg::cmd_t      cmd,
    output logic               busy,
    output logic               done
);
    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_DEC  = 11'b00000000010,
        S_CLNK = 11'b00000000100,
        S_TAKE = 11'b00000001000,
        S_INS1 = 11'b00000010000,
        S_INS2 = 11'b00000100000,
        S_DEL0 = 11'b00001000000,
        S_DEL1 = 11'b00010000000,
        S_DEL2 = 11'b00100000000,
        S_CVAL = 11'b01000000000,
        S_FIN  = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    // sequencing
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                if (!sts.pre_ok || sts.simple)
                begin
                    state_next = S_FIN;
                end
                else if (sts.ins && !sts.pool_ok)
                begin
                    state_next = S_FIN;
                end
                else if (sts.cur_op)
                begin
                    state_next = S_CLNK;
                end
                else if (sts.ins)
                begin
                    state_next = S_TAKE;
                end
                else
                begin
                    state_next = S_DEL0;
                end
            end
            S_CLNK:
            begin
                if (sts.move)
                begin
                    state_next = sts.lnk_ok ? S_CVAL : S_FIN;
                end
                else if (sts.del)
                begin
                    state_next = S_DEL0;
                end
                else
                begin
                    state_next = S_TAKE;
                end
            end
            S_TAKE: state_next = S_INS1;
            S_INS1: state_next = S_INS2;
            S_INS2: state_next = S_FIN;
            S_DEL0: state_next = S_DEL1;
            S_DEL1: state_next = S_DEL2;
            S_DEL2: state_next = S_FIN;
            S_CVAL: state_next = S_FIN;
            S_FIN:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // step strobes
    always_comb
    begin
        cmd.latch = (state_reg == S_IDLE) && start;
        cmd.dec   = (state_reg == S_DEC);
        cmd.clnk  = (state_reg == S_CLNK);
        cmd.take  = (state_reg == S_TAKE);
        cmd.ins1  = (state_reg == S_INS1);
        cmd.ins2  = (state_reg == S_INS2);
        cmd.del0  = (state_reg == S_DEL0);
        cmd.del1  = (state_reg == S_DEL1);
        cmd.del2  = (state_reg == S_DEL2);
        cmd.cval  = (state_reg == S_CVAL);
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FIN);

endmodule
`default_nettype wire

/* sv/llc_checker.sv */
`default_nettype none
module llc_checker (
    input wire logic          clk,
    input wire logic          rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire logic          done,
    input wire llc_pkg::out_t result
);
    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accept did not raise busy");

    // a result beat lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beat longer than one cycle");

    // a result is only shown while an item is in flight
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    // an empty list has no elements and no active cursor
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.list_empty |-> result.element_count == 9'd0 && !result.cursor_active)
        else $error("empty list reports elements or cursor");

endmodule

bind linked_list_cursor_engine llc_checker u_llc_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
`default_nettype wire

/* tb/sv/linked_list_cursor_engine_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module linked_list_cursor_engine_tb;

    localparam int NODES = llc_pkg::POOL_NODES_DEF;
    localparam logic [8:0] NIL = 9'(NODES);
    // operation code with no meaning
    localparam logic [3:0] OP_UNUSED = 4'd15;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    llc_pkg::in_t request;
    logic done;
    llc_pkg::out_t result;

    linked_list_cursor_engine uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // list shadow
    logic [31:0] val_mem [NODES];
    logic [8:0] nxt_mem [NODES];
    logic [8:0] prv_mem [NODES];
    logic [8:0] head_idx, tail_idx, cur_idx, free_idx, fresh_idx, len;

    llc_pkg::out_t list_reports [$];
    int mismatches;
    int gap_pct;

    function automatic logic live(logic [8:0] i);
        return i < NIL;
    endfunction

    function automatic void list_clear();
        head_idx = NIL;
        tail_idx = NIL;
        cur_idx = NIL;
        len = 0;
        free_idx = NIL;
        fresh_idx = 0;
    endfunction

    function automatic logic [1:0] link_in(logic [8:0] p, logic [8:0] q, logic [31:0] v);
        logic [8:0] n;
        if (live(free_idx))
        begin
            n = free_idx;
            free_idx = nxt_mem[n];
        end
        else if (fresh_idx < NIL)
        begin
            n = fresh_idx;
            fresh_idx++;
        end
        else
            return llc_pkg::ST_FULL;
        val_mem[n] = v;
        prv_mem[n] = p;
        nxt_mem[n] = q;
        if (live(p)) nxt_mem[p] = n; else head_idx = n;
        if (live(q)) prv_mem[q] = n; else tail_idx = n;
        len++;
        return llc_pkg::ST_DONE;
    endfunction

    function automatic logic [1:0] unlink(logic [8:0] n);
        logic [8:0] p, q;
        if (!live(n))
            return llc_pkg::ST_FAIL;
        p = prv_mem[n];
        q = nxt_mem[n];
        if (live(p)) nxt_mem[p] = q; else head_idx = q;
        if (live(q)) prv_mem[q] = p; else tail_idx = p;
        if (cur_idx == n) cur_idx = NIL;
        nxt_mem[n] = free_idx;
        free_idx = n;
        if (len > 0) len--;
        return llc_pkg::ST_DONE;
    endfunction

    // apply one operation to the shadow list and return the report
    function automatic llc_pkg::out_t list_apply(llc_pkg::in_t req);
        llc_pkg::out_t r;
        logic [1:0] st;
        logic act;
        logic [31:0] v;
        st = llc_pkg::ST_DONE;
        act = live(cur_idx);
        v = req.item_value;
        case (req.operation)
            llc_pkg::OP_CLEAR: list_clear();
            llc_pkg::OP_INS_FIRST: st = link_in(NIL, head_idx, v);
            llc_pkg::OP_INS_LAST: st = link_in(tail_idx, NIL, v);
            llc_pkg::OP_CUR_FIRST:
                if (live(head_idx)) cur_idx = head_idx; else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_CUR_LAST:
                if (live(tail_idx)) cur_idx = tail_idx; else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_DEL_FIRST: st = unlink(head_idx);
            llc_pkg::OP_DEL_LAST: st = unlink(tail_idx);
            llc_pkg::OP_DEL_AFTER:
                if (act && cur_idx != tail_idx) st = unlink(nxt_mem[cur_idx]);
                else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_DEL_BEFORE:
                if (act && cur_idx != head_idx) st = unlink(prv_mem[cur_idx]);
                else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_INS_AFTER:
                if (act) st = link_in(cur_idx, nxt_mem[cur_idx], v);
                else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_INS_BEFORE:
                if (act) st = link_in(prv_mem[cur_idx], cur_idx, v);
                else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_OVERWRITE:
                if (act) val_mem[cur_idx] = v; else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_NEXT:
                if (act) cur_idx = nxt_mem[cur_idx]; else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_PREV:
                if (act) cur_idx = prv_mem[cur_idx]; else st = llc_pkg::ST_FAIL;
            llc_pkg::OP_QUERY: ;
            default: st = llc_pkg::ST_FAIL;
        endcase
        if (!live(cur_idx)) cur_idx = NIL;
        r.first_value = live(head_idx) ? val_mem[head_idx] : 32'd0;
        r.last_value = live(tail_idx) ? val_mem[tail_idx] : 32'd0;
        r.cursor_value = live(cur_idx) ? val_mem[cur_idx] : 32'd0;
        r.list_empty = !live(head_idx);
        r.cursor_active = live(cur_idx);
        r.element_count = len;
        r.status = st;
        return r;
    endfunction

    // send one beat; prediction is made at acceptance
    task automatic send_op(logic [3:0] op, logic [31:0] v);
        llc_pkg::in_t req;
        while (busy)
            @(negedge clk);
        while ($urandom_range(99) < gap_pct)
            @(negedge clk);
        req.operation = op;
        req.item_value = v;
        request <= req;
        start <= 1'b1;
        // busy is low through this cycle, so the beat is taken at this edge
        @(posedge clk);
        list_reports.push_back(list_apply(req));
        @(negedge clk);
        start <= 1'b0;
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (list_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %p", result);
            end
            else
            begin
                llc_pkg::out_t e;
                e = list_reports.pop_front();
                if (result !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", e, result);
                end
            end
        end
    end

    function automatic logic [31:0] rand_val();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_cases();
        logic [3:0] op;
        for (int i = 3; i <= 15; i++)
        begin
            op = 4'(i);
            send_op(op, rand_val());
        end
    endtask

    task automatic test_directed();
        send_op(llc_pkg::OP_INS_FIRST, 32'h7fff_ffff);
        send_op(llc_pkg::OP_DEL_FIRST, 0);
        send_op(llc_pkg::OP_INS_LAST, 32'h8000_0000);
        send_op(llc_pkg::OP_DEL_LAST, 0);
        send_op(llc_pkg::OP_INS_LAST, 32'h1);
        send_op(llc_pkg::OP_INS_FIRST, 32'hffff_ffff);
        send_op(llc_pkg::OP_CUR_LAST, 0);
        send_op(llc_pkg::OP_INS_AFTER, 32'h5555_aaaa);
        send_op(llc_pkg::OP_CUR_FIRST, 0);
        send_op(llc_pkg::OP_INS_BEFORE, 32'haaaa_5555);
        send_op(llc_pkg::OP_DEL_BEFORE, 0);
        send_op(llc_pkg::OP_DEL_AFTER, 0);
        send_op(llc_pkg::OP_OVERWRITE, 32'h1234_5678);
        send_op(llc_pkg::OP_PREV, 0);
        send_op(llc_pkg::OP_CUR_LAST, 0);
        send_op(llc_pkg::OP_DEL_AFTER, 0);
        send_op(llc_pkg::OP_NEXT, 0);
        send_op(llc_pkg::OP_QUERY, 0);
        send_op(llc_pkg::OP_CLEAR, 0);
    endtask

    // fill the pool, hit the full case, then free some nodes, refill and clear
    task automatic test_pool_full();
        for (int i = 0; i < NODES + 2; i++)
            send_op($urandom_range(1) ? llc_pkg::OP_INS_FIRST : llc_pkg::OP_INS_LAST,
                    $urandom);
        send_op(llc_pkg::OP_CUR_FIRST, 0);
        send_op(llc_pkg::OP_INS_AFTER, 1);
        send_op(llc_pkg::OP_INS_BEFORE, 2);
        for (int i = 0; i < 6; i++)
            send_op(llc_pkg::OP_DEL_FIRST, 0);
        for (int i = 0; i < 8; i++)
            send_op(llc_pkg::OP_INS_LAST, $urandom);
        send_op(llc_pkg::OP_CLEAR, 0);
    endtask

    task automatic test_random(int n);
        logic [3:0] op;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(49) == 0) op = llc_pkg::OP_CLEAR;
            else if ($urandom_range(9) < 4) op = 4'($urandom_range(1, 2));
            else if ($urandom_range(19) == 0) op = OP_UNUSED;
            else op = 4'($urandom_range(3, 14));
            send_op(op, rand_val());
        end
    endtask

    initial
    begin
        start = 1'b0;
        request = '0;
        rst_n = 1'b0;
        mismatches = 0;
        gap_pct = 8;
        list_clear();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_empty_cases();
        test_directed();
        test_pool_full();
        test_random(30);
        gap_pct = 86;
        test_random(30);
        gap_pct = 0;
        test_random(30);
        while (list_reports.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("linked_list_cursor_engine_tb passed");
        else
            $display("linked_list_cursor_engine_tb failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("linked_list_cursor_engine_tb failed");
        $finish;
    end
endmodule
`default_nettype wire

/* linked_list_cursor_engine.f */
sv/llc_pkg.sv
sv/llc_datapath.sv
sv/llc_ctrl.sv
sv/linked_list_cursor_engine.sv
sv/llc_checker.sv
tb/sv/linked_list_cursor_engine_tb.sv
